/* rtl/ir_beam_break_detector_macros.svh */
// ============================================================================
// ir beam break detector assertion macros
// shared assertion helpers; removed when NO_ASSERTIONS is defined
// ============================================================================
`ifndef IR_BEAM_BREAK_DETECTOR_MACROS_SVH
`define IR_BEAM_BREAK_DETECTOR_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define IBBD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ibbd assertion failed");

// next-cycle implication
`define IBBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ibbd assertion failed");

`else

`define IBBD_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define IBBD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/ibbd_pkg.sv */
// ============================================================================
// ibbd_pkg
// types and constants of the ir beam break detector
// ============================================================================
`default_nettype none

package ibbd_pkg;

    localparam int SLOTS_DEFAULT = 4;

    localparam int WIN_W   = 10;
    localparam int CNT_W   = 8;
    localparam int BTIME_W = 12;
    localparam int BMISS_W = 4;
    localparam int ALARM_W = 16;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [WIN_W-1:0]   WINDOW_TICKS_RST    = 10'd100;
    localparam logic [CNT_W-1:0]   PULSE_THRESHOLD_RST = 8'd5;
    localparam logic [BTIME_W-1:0] BOUNCE_TICKS_RST    = 12'd350;
    localparam logic [BMISS_W-1:0] BOUNCE_MISS_RST     = 4'd2;
    localparam logic [ALARM_W-1:0] ALARM_TICKS_RST     = 16'd1000;
    localparam logic               BOUNCE_ENABLE_RST   = 1'b1;

    localparam logic [CNT_W-1:0]   CNT_MAX   = 8'd255;
    localparam logic [BMISS_W-1:0] BMISS_MAX = 4'd15;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TICKS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUNCE_TICKS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUNCE_MISS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ALARM_TICKS     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUNCE_ENABLE   = 3'd5;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_PIN  = 1'b1;

    typedef struct packed {
        logic command;
        logic sensor_one;
        logic sensor_two;
        logic sensor_three;
    } t_in;

    typedef struct packed {
        logic relay_n;
        logic buzzer;
        logic window_end;
        logic window_missed;
    } t_out;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DEC  = 6'b000010,
        S_CLR  = 6'b000100,
        S_WIN  = 6'b001000,
        S_OPEN = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

endpackage

`default_nettype wire

/* rtl/ir_beam_break_detector.sv */
// ============================================================================
// ir_beam_break_detector
// three-sensor beam break detector with counting windows, bounce slots and
// a timed alarm output
// ============================================================================
// input channel: i_valid / o_stall carry one transaction, either a 1 ms tick
// or a pin change with three sensor levels. output channel: o_valid / i_stall
// carry one result transaction per input (relay, buzzer, window flags).
// configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx.
// sequence: a pin change updates the pulse counts and goes straight to the
// output step. a tick walks the slot ring with one shared slot update unit,
// one slot per cycle, with a slot clearing pass whenever the alarm starts,
// a window check, and a slot opening pass when a missed window opens a slot,
// before the output step.
// throughput: one transaction at a time; o_stall is high from accept until
// the result has moved into the output register.
// a held result does not block the next input; if the output register is
// still full and stalled, the sequencer waits in its last step.
// reset (synchronous, active low) loads the default configuration, clears
// all counts, timers and slots and loads the window timer.
// ============================================================================
`default_nettype none
`include "ir_beam_break_detector_macros.svh"

module ir_beam_break_detector #(
    parameter int SLOTS = ibbd_pkg::SLOTS_DEFAULT
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_valid,
    output logic                              o_stall,
    input  ibbd_pkg::t_in                     i_data,
    output logic                              o_valid,
    input  wire                               i_stall,
    output ibbd_pkg::t_out                    o_data,
    input  wire                               i_cfg_we,
    input  wire  [ibbd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire  [ibbd_pkg::CFG_W-1:0]        i_cfg_data
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    // configuration
    logic [ibbd_pkg::WIN_W-1:0]   r_window_ticks;
    logic [ibbd_pkg::CNT_W-1:0]   r_pulse_threshold;
    logic [ibbd_pkg::BTIME_W-1:0] r_bounce_ticks;
    logic [ibbd_pkg::BMISS_W-1:0] r_bounce_miss;
    logic [ibbd_pkg::ALARM_W-1:0] r_alarm_ticks;
    logic                         r_bounce_enable;

    // state
    ibbd_pkg::t_state             r_state;
    logic [ibbd_pkg::WIN_W-1:0]   r_window_timer;
    logic [ibbd_pkg::CNT_W-1:0]   r_pulse_count [3];
    logic [ibbd_pkg::ALARM_W-1:0] r_alarm_timer;
    logic                         r_alarm_on;
    logic [ibbd_pkg::BTIME_W-1:0] r_slot_time   [SLOTS];
    logic [ibbd_pkg::BMISS_W-1:0] r_slot_misses [SLOTS];
    logic [IDX_W-1:0]             r_ptr;
    logic [IDX_W-1:0]             r_idx;
    logic                         r_fire;
    logic                         r_clr_to_win;
    logic                         r_ended;
    logic                         r_missed;
    logic                         r_out_valid;
    ibbd_pkg::t_out               r_out;

    // shared slot update unit
    logic [ibbd_pkg::BTIME_W-1:0] w_cur_time;
    logic [ibbd_pkg::BMISS_W-1:0] w_cur_misses;
    logic [ibbd_pkg::BTIME_W-1:0] n_slot_time;
    logic [ibbd_pkg::BMISS_W-1:0] n_slot_misses;
    logic                         w_slot_fire;
    logic                         w_last;
    logic                         w_accept;
    logic                         w_win_missed;
    logic                         w_out_load;

    assign w_cur_time   = r_slot_time[r_idx];
    assign w_cur_misses = r_slot_misses[r_idx];
    assign w_last       = (r_idx == LAST_IDX);
    assign w_accept     = i_valid && !o_stall;
    assign w_out_load   = (r_state == ibbd_pkg::S_OUT) && (!r_out_valid || !i_stall);

    always_comb begin
        n_slot_time   = w_cur_time;
        n_slot_misses = w_cur_misses;
        w_slot_fire   = 1'b0;
        case (r_state)
            ibbd_pkg::S_DEC: begin
                if (w_cur_time != '0) begin
                    n_slot_time = w_cur_time - 1'b1;
                end
                w_slot_fire = r_bounce_enable && (n_slot_time == '0)
                              && (w_cur_misses >= r_bounce_miss);
            end
            ibbd_pkg::S_CLR: begin
                n_slot_time   = '0;
                n_slot_misses = '0;
            end
            ibbd_pkg::S_OPEN: begin
                if (r_idx == r_ptr) begin
                    n_slot_time   = r_bounce_ticks;
                    n_slot_misses = '0;
                end
                if (n_slot_time != '0 && n_slot_misses != ibbd_pkg::BMISS_MAX) begin
                    n_slot_misses = n_slot_misses + 1'b1;
                end
            end
            default: begin
                n_slot_time   = w_cur_time;
                n_slot_misses = w_cur_misses;
            end
        endcase
    end

    assign w_win_missed = (r_pulse_count[0] <= r_pulse_threshold)
                       || (r_pulse_count[1] <= r_pulse_threshold)
                       || (r_pulse_count[2] <= r_pulse_threshold);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_ticks    <= ibbd_pkg::WINDOW_TICKS_RST;
            r_pulse_threshold <= ibbd_pkg::PULSE_THRESHOLD_RST;
            r_bounce_ticks    <= ibbd_pkg::BOUNCE_TICKS_RST;
            r_bounce_miss     <= ibbd_pkg::BOUNCE_MISS_RST;
            r_alarm_ticks     <= ibbd_pkg::ALARM_TICKS_RST;
            r_bounce_enable   <= ibbd_pkg::BOUNCE_ENABLE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ibbd_pkg::CFG_WINDOW_TICKS:
                    r_window_ticks <= i_cfg_data[ibbd_pkg::WIN_W-1:0];
                ibbd_pkg::CFG_PULSE_THRESHOLD:
                    r_pulse_threshold <= i_cfg_data[ibbd_pkg::CNT_W-1:0];
                ibbd_pkg::CFG_BOUNCE_TICKS:
                    r_bounce_ticks <= i_cfg_data[ibbd_pkg::BTIME_W-1:0];
                ibbd_pkg::CFG_BOUNCE_MISS:
                    r_bounce_miss <= i_cfg_data[ibbd_pkg::BMISS_W-1:0];
                ibbd_pkg::CFG_ALARM_TICKS:
                    r_alarm_ticks <= i_cfg_data[ibbd_pkg::ALARM_W-1:0];
                ibbd_pkg::CFG_BOUNCE_ENABLE:
                    r_bounce_enable <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // slot ring, one entry updated per cycle during the decrement, clear and open passes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_slot_time[i]   <= '0;
                r_slot_misses[i] <= '0;
            end
        end else if (r_state == ibbd_pkg::S_DEC || r_state == ibbd_pkg::S_CLR
                     || r_state == ibbd_pkg::S_OPEN) begin
            r_slot_time[r_idx]   <= n_slot_time;
            r_slot_misses[r_idx] <= n_slot_misses;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ibbd_pkg::S_IDLE;
            r_window_timer <= ibbd_pkg::WINDOW_TICKS_RST;
            for (int i = 0; i < 3; i++) begin
                r_pulse_count[i] <= '0;
            end
            r_alarm_timer  <= '0;
            r_alarm_on     <= 1'b0;
            r_ptr          <= '0;
            r_idx          <= '0;
            r_fire         <= 1'b0;
            r_clr_to_win   <= 1'b0;
            r_ended        <= 1'b0;
            r_missed       <= 1'b0;
        end else begin
            case (r_state)
                ibbd_pkg::S_IDLE: begin
                    if (w_accept) begin
                        r_idx    <= '0;
                        r_fire   <= 1'b0;
                        r_ended  <= 1'b0;
                        r_missed <= 1'b0;
                        if (i_data.command == ibbd_pkg::CMD_PIN) begin
                            if (r_window_timer != '0) begin
                                if (!i_data.sensor_one && r_pulse_count[0] != ibbd_pkg::CNT_MAX)
                                    r_pulse_count[0] <= r_pulse_count[0] + 1'b1;
                                if (!i_data.sensor_two && r_pulse_count[1] != ibbd_pkg::CNT_MAX)
                                    r_pulse_count[1] <= r_pulse_count[1] + 1'b1;
                                if (!i_data.sensor_three && r_pulse_count[2] != ibbd_pkg::CNT_MAX)
                                    r_pulse_count[2] <= r_pulse_count[2] + 1'b1;
                            end
                            r_state <= ibbd_pkg::S_OUT;
                        end else begin
                            if (r_window_timer != '0)
                                r_window_timer <= r_window_timer - 1'b1;
                            if (r_alarm_timer != '0)
                                r_alarm_timer <= r_alarm_timer - 1'b1;
                            r_state <= ibbd_pkg::S_DEC;
                        end
                    end
                end
                ibbd_pkg::S_DEC: begin
                    r_idx <= w_last ? '0 : r_idx + 1'b1;
                    if (w_last) begin
                        if (r_fire || w_slot_fire) begin
                            r_alarm_on    <= 1'b1;
                            r_alarm_timer <= r_alarm_ticks;
                            r_clr_to_win  <= 1'b1;
                            r_state       <= ibbd_pkg::S_CLR;
                        end else begin
                            if (r_alarm_timer == '0)
                                r_alarm_on <= 1'b0;
                            r_state <= ibbd_pkg::S_WIN;
                        end
                    end else if (w_slot_fire) begin
                        r_fire <= 1'b1;
                    end
                end
                ibbd_pkg::S_CLR: begin
                    r_idx <= w_last ? '0 : r_idx + 1'b1;
                    if (w_last) begin
                        r_state <= r_clr_to_win ? ibbd_pkg::S_WIN : ibbd_pkg::S_OUT;
                    end
                end
                ibbd_pkg::S_WIN: begin
                    if (r_window_timer == '0) begin
                        r_ended  <= 1'b1;
                        r_missed <= w_win_missed;
                        for (int i = 0; i < 3; i++) begin
                            r_pulse_count[i] <= '0;
                        end
                        r_window_timer <= r_window_ticks;
                        if (w_win_missed) begin
                            if (r_bounce_enable) begin
                                r_state <= ibbd_pkg::S_OPEN;
                            end else begin
                                r_alarm_on    <= 1'b1;
                                r_alarm_timer <= r_alarm_ticks;
                                r_clr_to_win  <= 1'b0;
                                r_state       <= ibbd_pkg::S_CLR;
                            end
                        end else begin
                            r_state <= ibbd_pkg::S_OUT;
                        end
                    end else begin
                        r_state <= ibbd_pkg::S_OUT;
                    end
                end
                ibbd_pkg::S_OPEN: begin
                    r_idx <= w_last ? '0 : r_idx + 1'b1;
                    if (w_last) begin
                        r_ptr   <= (r_ptr == LAST_IDX) ? '0 : r_ptr + 1'b1;
                        r_state <= ibbd_pkg::S_OUT;
                    end
                end
                ibbd_pkg::S_OUT: begin
                    if (w_out_load) begin
                        r_state <= ibbd_pkg::S_IDLE;
                    end
                end
                default: begin
                    r_state <= ibbd_pkg::S_IDLE;
                end
            endcase
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out.relay_n       <= !r_alarm_on;
            r_out.buzzer        <= r_alarm_on;
            r_out.window_end    <= r_ended;
            r_out.window_missed <= r_missed;
        end
    end

    assign o_stall = (r_state != ibbd_pkg::S_IDLE);
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    `IBBD_ASSERT_IMPLY(a_idx_range, i_clk, i_rst_n, 1'b1, r_idx <= LAST_IDX)
    `IBBD_ASSERT_IMPLY(a_ptr_range, i_clk, i_rst_n, 1'b1, r_ptr <= LAST_IDX)
    `IBBD_ASSERT_NEXT(a_tick_walks, i_clk, i_rst_n, w_accept && i_data.command == ibbd_pkg::CMD_TICK, r_state == ibbd_pkg::S_DEC)
    `IBBD_ASSERT_IMPLY(a_drive_match, i_clk, i_rst_n, o_valid, o_data.relay_n != o_data.buzzer)
    `IBBD_ASSERT_IMPLY(a_miss_needs_end, i_clk, i_rst_n, o_valid && o_data.window_missed, o_data.window_end)

endmodule

`default_nettype wire
